>>> rtl/core/closest_point_on_segment_core_assert.svh
// ----------------------------------------------------------------------------
// Closest point on segment: assertion macros
// Shared concurrent assertion forms for the core.
// ----------------------------------------------------------------------------
`ifndef CLOSEST_POINT_ON_SEGMENT_CORE_ASSERT_SVH
`define CLOSEST_POINT_ON_SEGMENT_CORE_ASSERT_SVH

// a implies b in the same cycle
`define CPOS_ASSERT_IMPLY(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("cpos: implication check failed");

// a implies b in the next cycle
`define CPOS_ASSERT_NEXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("cpos: next-cycle check failed");

`endif

>>> rtl/core/cpos_pkg.sv
// ----------------------------------------------------------------------------
// Closest point on segment: package
// Shared widths and pipeline side-band types.
// ----------------------------------------------------------------------------
package cpos_pkg;

   localparam int RAD_W  = 32;   // radicand of the length root
   localparam int ROOT_W = 16;   // segment length

   typedef struct packed {
      logic signed [14:0] ax;
      logic signed [14:0] ay;
      logic signed [15:0] dx;
      logic signed [15:0] dy;
      logic [14:0]        margin;
   } geom_type;

   typedef struct packed {
      geom_type           g;
      logic signed [31:0] dot;
   } sq_side_type;

   typedef struct packed {
      geom_type          g;
      logic [ROOT_W-1:0] len;
      logic              dot_pos;
      logic              sat;
   } pj_side_type;

   typedef struct packed {
      logic signed [14:0] ax;
      logic signed [14:0] ay;
      logic               nx;
      logic               short_seg;
   } sc_side_type;

endpackage

>>> rtl/core/cpos_isqrt.sv
// ----------------------------------------------------------------------------
// Closest point on segment: pipelined integer square root
// One result bit per stage, floor root of a 32-bit radicand.
// ----------------------------------------------------------------------------
module cpos_isqrt #(
   parameter int SIDE_W = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [cpos_pkg::RAD_W-1:0]    in_rad,
   input  logic [SIDE_W-1:0]             in_side,
   output logic                          out_valid,
   output logic [cpos_pkg::ROOT_W-1:0]   out_root,
   output logic [SIDE_W-1:0]             out_side
);

   localparam int STAGES = cpos_pkg::ROOT_W;
   localparam int REM_W  = cpos_pkg::ROOT_W + 2;

   logic                          v_ff    [STAGES];
   logic [cpos_pkg::RAD_W-1:0]    rad_ff  [STAGES];
   logic [REM_W-1:0]              rem_ff  [STAGES];
   logic [cpos_pkg::ROOT_W-1:0]   root_ff [STAGES];
   logic [SIDE_W-1:0]             side_ff [STAGES];

   for (genvar g = 0; g < STAGES; g++) begin : gen_stage
      logic                        src_v;
      logic [cpos_pkg::RAD_W-1:0]  src_rad;
      logic [REM_W-1:0]            src_rem;
      logic [cpos_pkg::ROOT_W-1:0] src_root;
      logic [SIDE_W-1:0]           src_side;
      logic [REM_W+1:0]            trial;
      logic [REM_W+1:0]            test;
      logic [REM_W+1:0]            diff;
      logic                        ge;

      if (g == 0) begin : gen_first
         assign src_v    = in_valid;
         assign src_rad  = in_rad;
         assign src_rem  = '0;
         assign src_root = '0;
         assign src_side = in_side;
      end else begin : gen_next
         assign src_v    = v_ff[g-1];
         assign src_rad  = rad_ff[g-1];
         assign src_rem  = rem_ff[g-1];
         assign src_root = root_ff[g-1];
         assign src_side = side_ff[g-1];
      end

      always_comb begin
         trial = {src_rem, src_rad[cpos_pkg::RAD_W-1 -: 2]};
         test  = {{(REM_W - cpos_pkg::ROOT_W){1'b0}}, src_root, 2'b01};
         diff  = trial - test;
         ge    = (trial >= test);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[g] <= 1'b0;
         end else if (en) begin
            v_ff[g] <= src_v;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[g]  <= src_rad << 2;
            rem_ff[g]  <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
            root_ff[g] <= {src_root[cpos_pkg::ROOT_W-2:0], ge};
            side_ff[g] <= src_side;
         end
      end
   end

   assign out_valid = v_ff[STAGES-1];
   assign out_root  = root_ff[STAGES-1];
   assign out_side  = side_ff[STAGES-1];

endmodule

>>> rtl/core/cpos_udiv.sv
// ----------------------------------------------------------------------------
// Closest point on segment: pipelined unsigned divider
// Restoring division, one quotient bit per stage. The caller keeps the
// dividend below divisor * 2^Q so the quotient fits Q bits.
// ----------------------------------------------------------------------------
module cpos_udiv #(
   parameter int D      = 16,
   parameter int Q      = 16,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [Q+D-1:0]    in_dividend,
   input  logic [D-1:0]      in_divisor,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [Q-1:0]      out_quot,
   output logic [SIDE_W-1:0] out_side
);

   logic              v_ff    [Q];
   logic [D-1:0]      rem_ff  [Q];
   logic [Q-1:0]      low_ff  [Q];
   logic [D-1:0]      div_ff  [Q];
   logic [SIDE_W-1:0] side_ff [Q];

   for (genvar g = 0; g < Q; g++) begin : gen_stage
      logic              src_v;
      logic [D-1:0]      src_rem;
      logic [Q-1:0]      src_low;
      logic [D-1:0]      src_div;
      logic [SIDE_W-1:0] src_side;
      logic [D:0]        trial;
      logic [D:0]        diff;
      logic              ge;

      if (g == 0) begin : gen_first
         assign src_v    = in_valid;
         assign src_rem  = in_dividend[Q+D-1:Q];
         assign src_low  = in_dividend[Q-1:0];
         assign src_div  = in_divisor;
         assign src_side = in_side;
      end else begin : gen_next
         assign src_v    = v_ff[g-1];
         assign src_rem  = rem_ff[g-1];
         assign src_low  = low_ff[g-1];
         assign src_div  = div_ff[g-1];
         assign src_side = side_ff[g-1];
      end

      always_comb begin
         trial = {src_rem, src_low[Q-1]};
         diff  = trial - {1'b0, src_div};
         ge    = (trial >= {1'b0, src_div});
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[g] <= 1'b0;
         end else if (en) begin
            v_ff[g] <= src_v;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[g]  <= ge ? diff[D-1:0] : trial[D-1:0];
            low_ff[g]  <= {src_low[Q-2:0], ge};
            div_ff[g]  <= src_div;
            side_ff[g] <= src_side;
         end
      end
   end

   assign out_valid = v_ff[Q-1];
   assign out_quot  = low_ff[Q-1];
   assign out_side  = side_ff[Q-1];

endmodule

>>> rtl/core/closest_point_on_segment_core.sv
// ----------------------------------------------------------------------------
// Closest point on segment: core
// Projects a query point onto segment A-B with an optional end margin.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one query item: segment ends, query point and margin.
//   rsp_* returns one item per query, the closest point on the segment.
//   Items are taken on req_tvalid & req_tready and leave on
//   rsp_tvalid & rsp_tready, strictly in order.
// Throughput: one item per cycle, sustained while results are taken at the output.
// Path: an item passes the 16-stage length root, the 16-stage projection
//   divider and the 15-stage rescale dividers, plus seven arithmetic stages
//   and the output register.
// Stall: the pipeline keeps moving while one result waits at the output;
//   a second waiting result lands in a skid register and only then is
//   req_tready dropped, so nothing is lost or repeated.
// Reset: synchronous, clears all valid flags; the pipeline starts empty.
// ----------------------------------------------------------------------------
`include "closest_point_on_segment_core_assert.svh"

module closest_point_on_segment_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // start_x, start_y, end_x, end_y, query_x, query_y, end_margin, 7'b0
   input  logic [111:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // near_x, near_y, 2'b0
   output logic [31:0]  rsp_tdata
);

   localparam int LW = cpos_pkg::ROOT_W;

   logic en;

   // ---- stage 1: differences
   logic signed [14:0] in_ax, in_ay, in_bx, in_by, in_cx, in_cy;
   cpos_pkg::geom_type s1_g;
   logic signed [15:0] s1_ex, s1_ey;
   logic               s1_v_ff;

   assign in_ax = req_tdata[14:0];
   assign in_ay = req_tdata[29:15];
   assign in_bx = req_tdata[44:30];
   assign in_by = req_tdata[59:45];
   assign in_cx = req_tdata[74:60];
   assign in_cy = req_tdata[89:75];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_g.ax     <= in_ax;
         s1_g.ay     <= in_ay;
         s1_g.dx     <= 16'(in_bx) - 16'(in_ax);
         s1_g.dy     <= 16'(in_by) - 16'(in_ay);
         s1_g.margin <= req_tdata[104:90];
         s1_ex       <= 16'(in_cx) - 16'(in_ax);
         s1_ey       <= 16'(in_cy) - 16'(in_ay);
      end
   end

   // ---- stage 2: products
   cpos_pkg::geom_type s2_g;
   logic signed [31:0] s2_xx, s2_yy, s2_xe, s2_ye;
   logic               s2_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (en) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_g  <= s1_g;
         s2_xx <= s1_g.dx * s1_g.dx;
         s2_yy <= s1_g.dy * s1_g.dy;
         s2_xe <= s1_g.dx * s1_ex;
         s2_ye <= s1_g.dy * s1_ey;
      end
   end

   // ---- stage 3: squared length and dot product
   cpos_pkg::sq_side_type s3_side;
   logic [31:0]           s3_sq;
   logic                  s3_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (en) begin
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_side.g   <= s2_g;
         s3_side.dot <= s2_xe + s2_ye;
         s3_sq       <= 32'(s2_xx + s2_yy);
      end
   end

   // ---- length root
   logic                  sr_v;
   logic [LW-1:0]         sr_root;
   cpos_pkg::sq_side_type sr_side;

   cpos_isqrt #(
      .SIDE_W ($bits(cpos_pkg::sq_side_type))
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s3_v_ff),
      .in_rad    (s3_sq),
      .in_side   (s3_side),
      .out_valid (sr_v),
      .out_root  (sr_root),
      .out_side  (sr_side)
   );

   // ---- stage 4: L squared, for the saturation test
   cpos_pkg::sq_side_type s4_side;
   logic [LW-1:0]         s4_len;
   logic [31:0]           s4_lsq;
   logic                  s4_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
      end else if (en) begin
         s4_v_ff <= sr_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_side <= sr_side;
         s4_len  <= sr_root;
         s4_lsq  <= sr_root * sr_root;
      end
   end

   // ---- projection divide: dot / L, only when 0 < dot < L*L
   cpos_pkg::pj_side_type pj_in, pj_out;
   logic [31:0]           pj_dividend;
   logic                  pj_v;
   logic [LW-1:0]         pj_q;

   always_comb begin
      pj_in.g       = s4_side.g;
      pj_in.len     = s4_len;
      pj_in.dot_pos = (s4_side.dot > 32'sd0);
      pj_in.sat     = ($unsigned(s4_side.dot) >= s4_lsq);
      pj_dividend   = (pj_in.dot_pos && !pj_in.sat) ? $unsigned(s4_side.dot) : '0;
   end

   cpos_udiv #(
      .D      (LW),
      .Q      (LW),
      .SIDE_W ($bits(cpos_pkg::pj_side_type))
   ) u_div_proj (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (s4_v_ff),
      .in_dividend (pj_dividend),
      .in_divisor  (s4_len),
      .in_side     (pj_in),
      .out_valid   (pj_v),
      .out_quot    (pj_q),
      .out_side    (pj_out)
   );

   // ---- m1: projection clamped to 0..L
   cpos_pkg::geom_type m1_g;
   logic [LW-1:0]      m1_len, m1_p;
   logic               m1_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_v_ff <= 1'b0;
      end else if (en) begin
         m1_v_ff <= pj_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_g   <= pj_out.g;
         m1_len <= pj_out.len;
         if (!pj_out.dot_pos) begin
            m1_p <= '0;
         end else if (pj_out.sat) begin
            m1_p <= pj_out.len;
         end else begin
            m1_p <= pj_q;
         end
      end
   end

   // ---- m2: end margin rule, component magnitudes
   logic [LW:0]        mg_m, mg_lm, mg_pm, mg_lo, mg_hi;
   logic               mg_fits;
   logic [LW-1:0]      m2_len, m2_p;
   logic [14:0]        m2_magx, m2_magy;
   logic               m2_nx, m2_ny;
   logic signed [14:0] m2_ax, m2_ay;
   logic               m2_v_ff;
   logic [15:0]        absx, absy;

   always_comb begin
      mg_m    = (LW+1)'(m1_g.margin);
      mg_lm   = (LW+1)'(m1_len) - mg_m;
      mg_pm   = (LW+1)'(m1_p) + mg_m;
      mg_lo   = (mg_pm < mg_lm) ? mg_pm : mg_lm;
      mg_hi   = (mg_lo > mg_m) ? mg_lo : mg_m;
      mg_fits = ((mg_m << 1) < (LW+1)'(m1_len));
      absx    = m1_g.dx[15] ? -m1_g.dx : m1_g.dx;
      absy    = m1_g.dy[15] ? -m1_g.dy : m1_g.dy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_v_ff <= 1'b0;
      end else if (en) begin
         m2_v_ff <= m1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m2_len  <= m1_len;
         m2_ax   <= m1_g.ax;
         m2_ay   <= m1_g.ay;
         m2_nx   <= m1_g.dx[15];
         m2_ny   <= m1_g.dy[15];
         m2_magx <= absx[14:0];
         m2_magy <= absy[14:0];
         if (m1_g.margin == '0) begin
            m2_p <= m1_p;
         end else if (mg_fits) begin
            m2_p <= mg_hi[LW-1:0];
         end else begin
            m2_p <= m1_len >> 1;
         end
      end
   end

   // ---- m3: |d| * p
   logic [30:0]           m3_numx, m3_numy;
   logic [LW-1:0]         m3_len;
   logic                  m3_ny;
   logic                  m3_v_ff;
   cpos_pkg::sc_side_type m3_side;

   always_ff @(posedge clock) begin
      if (reset) begin
         m3_v_ff <= 1'b0;
      end else if (en) begin
         m3_v_ff <= m2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m3_numx           <= m2_magx * m2_p;
         m3_numy           <= m2_magy * m2_p;
         m3_len            <= m2_len;
         m3_ny             <= m2_ny;
         m3_side.ax        <= m2_ax;
         m3_side.ay        <= m2_ay;
         m3_side.nx        <= m2_nx;
         m3_side.short_seg <= (m2_len <= LW'(1));
      end
   end

   // ---- rescale: (2 num + L) / 2L, rounds halves away from zero
   logic [31:0]           sc_divx, sc_divy;
   logic [LW:0]           sc_den;
   logic                  scx_v, scy_v;
   logic [14:0]           scx_q, scy_q;
   logic                  scy_neg;
   cpos_pkg::sc_side_type scx_side;

   assign sc_divx = {m3_numx, 1'b0} + 32'(m3_len);
   assign sc_divy = {m3_numy, 1'b0} + 32'(m3_len);
   assign sc_den  = {m3_len, 1'b0};

   cpos_udiv #(
      .D      (LW + 1),
      .Q      (15),
      .SIDE_W ($bits(cpos_pkg::sc_side_type))
   ) u_div_x (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (m3_v_ff),
      .in_dividend (sc_divx),
      .in_divisor  (sc_den),
      .in_side     (m3_side),
      .out_valid   (scx_v),
      .out_quot    (scx_q),
      .out_side    (scx_side)
   );

   cpos_udiv #(
      .D      (LW + 1),
      .Q      (15),
      .SIDE_W (1)
   ) u_div_y (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (m3_v_ff),
      .in_dividend (sc_divy),
      .in_divisor  (sc_den),
      .in_side     (m3_ny),
      .out_valid   (scy_v),
      .out_quot    (scy_q),
      .out_side    (scy_neg)
   );

   // ---- result and output / skid registers
   logic [29:0] res_data;
   logic [14:0] res_x, res_y;
   logic        out_v_ff, skid_v_ff;
   logic [29:0] out_data_ff, skid_data_ff;
   logic        out_take, new_v;

   always_comb begin
      res_x = scx_side.ax + (scx_side.nx ? -scx_q : scx_q);
      res_y = scx_side.ay + (scy_neg ? -scy_q : scy_q);
      if (scx_side.short_seg) begin
         res_x = scx_side.ax;
         res_y = scx_side.ay;
      end
      res_data = {res_y, res_x};
   end

   assign en         = !skid_v_ff;
   assign req_tready = en;
   assign out_take   = out_v_ff && rsp_tready;
   assign new_v      = en && scx_v;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         if (skid_v_ff) begin
            if (out_take) begin
               out_data_ff <= skid_data_ff;
               skid_v_ff   <= 1'b0;
            end
         end else if (new_v) begin
            if (!out_v_ff || out_take) begin
               out_data_ff <= res_data;
               out_v_ff    <= 1'b1;
            end else begin
               skid_data_ff <= res_data;
               skid_v_ff    <= 1'b1;
            end
         end else if (out_take) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {2'b00, out_data_ff};

   // ---- checks
   `CPOS_ASSERT_IMPLY(a_skid_needs_out, clock, reset, skid_v_ff, out_v_ff)
   `CPOS_ASSERT_IMPLY(a_lanes_lockstep, clock, reset, scx_v || scy_v, scx_v && scy_v)
   `CPOS_ASSERT_IMPLY(a_proj_in_range, clock, reset, m2_v_ff, m2_p <= m2_len)
   `CPOS_ASSERT_NEXT(a_skid_drains, clock, reset, skid_v_ff && rsp_tready, !skid_v_ff)

endmodule

>>> test/tb_closest_point_on_segment_core.sv
// ----------------------------------------------------------------------------
// Closest point on segment: core testbench
// Streams directed and random segment queries through the core with random
// gaps on both sides and checks every returned point against a predictor.
// ----------------------------------------------------------------------------
module tb_closest_point_on_segment_core;

   typedef struct {
      logic signed [14:0] ax, ay, bx, by, cx, cy;
      logic [14:0]        margin;
      bit                 drain;   // hold off until the pipeline is empty
   } query_type;

   typedef struct {
      logic [14:0] x, y;
   } point_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   // start_x, start_y, end_x, end_y, query_x, query_y, end_margin, 7'b0
   logic [111:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   // near_x, near_y, 2'b0
   logic [31:0]  rsp_tdata;

   query_type pending_q[$];
   point_type near_q[$];
   query_type cur_query;
   int        err_count = 0;
   int        sent_count = 0;
   int        got_count = 0;
   int        send_gap = 0;
   int        recv_stall = 0;
   bit        quiet_send = 0;
   bit        quiet_recv = 0;

   closest_point_on_segment_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic longint rescale(longint d, longint p, longint len);
      longint mag;
      longint q;
      mag = (d < 0) ? -d : d;
      q = (2 * mag * p + len) / (2 * len);
      return (d < 0) ? -q : q;
   endfunction

   function automatic point_type nearest_point(query_type q);
      longint dx, dy, ex, ey, len, p, m, rx, ry;
      point_type r;
      dx = longint'(q.bx) - longint'(q.ax);
      dy = longint'(q.by) - longint'(q.ay);
      ex = longint'(q.cx) - longint'(q.ax);
      ey = longint'(q.cy) - longint'(q.ay);
      m  = longint'({1'b0, q.margin});
      len = longint'(root_floor(longint'(dx * dx + dy * dy)));
      rx = longint'(q.ax);
      ry = longint'(q.ay);
      if (len > 1) begin
         p = (dx * ex + dy * ey) / len;
         if (m > 0) begin
            if (2 * m < len) begin
               p = (p > len) ? len : p;
               p = (p < 0) ? 0 : p;
               p = p + m;
               p = (p > len - m) ? len - m : p;
               p = (p < m) ? m : p;
            end else begin
               p = len / 2;
            end
         end
         p = (p > len) ? len : p;
         p = (p < 0) ? 0 : p;
         rx = rx + rescale(dx, p, len);
         ry = ry + rescale(dy, p, len);
      end
      r.x = rx[14:0];
      r.y = ry[14:0];
      return r;
   endfunction

   function automatic logic [111:0] pack_query(query_type q);
      return {7'b0, q.margin, q.cy, q.cx, q.by, q.bx, q.ay, q.ax};
   endfunction

   function automatic query_type make_query(int ax, int ay, int bx, int by,
                                            int cx, int cy, int m);
      query_type q;
      q.ax = 15'(ax); q.ay = 15'(ay); q.bx = 15'(bx); q.by = 15'(by);
      q.cx = 15'(cx); q.cy = 15'(cy); q.margin = 15'(m); q.drain = 0;
      return q;
   endfunction

   function automatic int clamp15(int v);
      if (v > 16383) return 16383;
      if (v < -16384) return -16384;
      return v;
   endfunction

   // Mostly well-formed geometry: short, mid and long segments near the query,
   // plus full-range noise and margin corners.
   function automatic query_type random_query();
      query_type q;
      int ax, ay, span, m;
      int kind;
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
         q = make_query($urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom);
      end else begin
         span = (kind < 6) ? 4 : ((kind < 8) ? 300 : 16000);
         ax = int'($urandom_range(0, 32767)) - 16384;
         ay = int'($urandom_range(0, 32767)) - 16384;
         case ($urandom_range(0, 3))
            0: m = 0;
            1: m = $urandom_range(1, 8);
            2: m = $urandom_range(1, span);
            default: m = $urandom_range(0, 32767);
         endcase
         q = make_query(ax, ay,
            clamp15(ax + int'($urandom_range(0, 2 * span)) - span),
            clamp15(ay + int'($urandom_range(0, 2 * span)) - span),
            clamp15(ax + int'($urandom_range(0, 4 * span)) - 2 * span),
            clamp15(ay + int'($urandom_range(0, 4 * span)) - 2 * span), m);
      end
      return q;
   endfunction

   task automatic report_mismatch(string msg);
      err_count++;
      $display("mismatch item %0d: %s", got_count, msg);
   endtask

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // Driver
   always @(posedge clock) begin
      bit nv;
      if (reset) begin
         req_tvalid <= 0;
         req_tdata  <= '0;
      end else begin
         nv = req_tvalid;
         if (req_tvalid && req_tready) begin
            near_q.push_back(nearest_point(cur_query));
            sent_count++;
            nv = 0;
            if ($urandom_range(0, 99) < 3) quiet_send = ~quiet_send;
            send_gap = quiet_send ? 0 : $urandom_range(0, 11);
         end
         if (!nv) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_q.size() > 0 &&
                         !(pending_q[0].drain && near_q.size() != 0)) begin
               cur_query = pending_q.pop_front();
               req_tdata <= pack_query(cur_query);
               nv = 1;
            end
         end
         req_tvalid <= nv;
      end
   end

   // Monitor
   always @(posedge clock) begin
      point_type want;
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (near_q.size() == 0) begin
               report_mismatch("result with no query outstanding");
            end else begin
               want = near_q.pop_front();
               if (rsp_tdata[14:0] !== want.x)
                  report_mismatch($sformatf("near_x got %0d expected %0d",
                                            $signed(rsp_tdata[14:0]), $signed(want.x)));
               if (rsp_tdata[29:15] !== want.y)
                  report_mismatch($sformatf("near_y got %0d expected %0d",
                                            $signed(rsp_tdata[29:15]), $signed(want.y)));
            end
            got_count++;
            if ($urandom_range(0, 99) < 3) quiet_recv = ~quiet_recv;
            recv_stall = quiet_recv ? 0 : $urandom_range(0, 11);
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= 1;
         end
      end
   end

   initial begin
      query_type q;
      reset = 1;
      // extremes, degenerate and short segments, margin cases
      pending_q.push_back(make_query(-16384, -16384, 16383, 16383, 0, 0, 0));
      pending_q.push_back(make_query(16383, 16383, -16384, -16384, 16383, -16384, 0));
      pending_q.push_back(make_query(-16384, 16383, 16383, -16384, -16384, -16384, 32767));
      pending_q.push_back(make_query(100, 100, 100, 100, 500, -500, 0));     // zero length
      pending_q.push_back(make_query(5, 5, 6, 5, 10, 10, 0));                // length one
      pending_q.push_back(make_query(-3, 7, -2, 8, 10, 10, 0));              // root floors to one
      pending_q.push_back(make_query(0, 0, 1000, 0, -500, 30, 0));           // before start
      pending_q.push_back(make_query(0, 0, 1000, 0, 5000, -30, 0));          // past end
      pending_q.push_back(make_query(0, 0, 1000, 0, 333, 77, 0));            // interior
      pending_q.push_back(make_query(0, 0, 1000, 0, 333, 77, 100));          // margin applies
      pending_q.push_back(make_query(0, 0, 1000, 0, -200, 0, 100));          // margin at start
      pending_q.push_back(make_query(0, 0, 1000, 0, 2000, 0, 100));          // margin at end
      pending_q.push_back(make_query(0, 0, 1000, 0, 10, 0, 500));            // too short: midpoint
      pending_q.push_back(make_query(0, 0, 7, 0, 3, 3, 32767));
      pending_q.push_back(make_query(-10, -10, -13, -14, -11, -12, 1));
      pending_q.push_back(make_query(0, 0, 3, 0, 1, 0, 0));                  // short segment, interior point
      pending_q.push_back(make_query(0, 0, -3, 0, -1, 0, 1));
      pending_q.push_back(make_query(16383, -16384, 16383, 16383, 0, 0, 16383));
      pending_q.push_back(make_query(-16384, 0, 16383, 0, 16383, 16383, 0));
      for (int i = 0; i < 1900; i++) begin
         q = random_query();
         if (i == 700 || i == 1400) q.drain = 1;
         pending_q.push_back(q);
      end
      repeat (11) @(posedge clock);
      reset <= 0;
      wait (pending_q.size() == 0);
      @(posedge clock);
      while (req_tvalid) @(posedge clock);
      while (near_q.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
      $display("covered %0d queries: extremes, degenerate, margin and clamp cases,",
               sent_count);
      $display("random segments with gaps and stalls; %0d points returned", got_count);
      if (err_count == 0 && near_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #1600000;
      $display("timeout with %0d results outstanding", near_q.size());
      $display("DONE: errors detected");
      $finish;
   end

endmodule
